// ===== sv/lbbs_pkg.sv =====
// Shared types and constants for the label bounding-box statistics block.
// No dependencies; every other file of the block imports this package.
`timescale 1ns / 1ps

package lbbs_pkg;

    localparam int LABEL_ENTRIES = 4096;
    localparam int IDX_W         = $clog2(LABEL_ENTRIES);
    localparam int LABEL_W       = 16;
    localparam int COORD_W       = 10;
    localparam int EXT_W         = COORD_W + 1;
    localparam int TALLY_W       = 30;
    localparam int QUEUE_DEPTH   = 4;
    localparam int QPTR_W        = $clog2(QUEUE_DEPTH);

    localparam logic [EXT_W-1:0]   EXT_LIMIT = EXT_W'(1 << COORD_W);
    localparam logic [TALLY_W-1:0] TALLY_MAX = {TALLY_W{1'b1}};
    localparam logic [IDX_W-1:0]   IDX_LAST  = IDX_W'(LABEL_ENTRIES - 1);

    // Input operation codes
    localparam logic [1:0] OP_ACC   = 2'd0;
    localparam logic [1:0] OP_READ  = 2'd1;
    localparam logic [1:0] OP_CLEAR = 2'd2;

    // Configuration register indexes
    localparam logic [1:0] CFG_COLUMNS = 2'd0;
    localparam logic [1:0] CFG_ROWS    = 2'd1;
    localparam logic [1:0] CFG_PLANES  = 2'd2;

    // Command class decided by the front end
    typedef enum logic [2:0] {
        K_ACC   = 3'd0,
        K_READ  = 3'd1,
        K_CLEAR = 3'd2,
        K_BAD   = 3'd3,
        K_NOP   = 3'd4
    } t_kind;

    typedef struct packed {
        t_kind                kind;
        logic [LABEL_W-1:0]   label;
        logic [COORD_W-1:0]   x;
        logic [COORD_W-1:0]   y;
        logic [COORD_W-1:0]   z;
        logic [LABEL_W-1:0]   top;
    } t_cmd;

    typedef struct packed {
        logic [TALLY_W-1:0] tally;
        logic [COORD_W-1:0] hi_z;
        logic [COORD_W-1:0] hi_y;
        logic [COORD_W-1:0] hi_x;
        logic [COORD_W-1:0] lo_z;
        logic [COORD_W-1:0] lo_y;
        logic [COORD_W-1:0] lo_x;
    } t_entry;

endpackage

// ===== sv/lbbs_front.sv =====
// Front end: accepts input beats, keeps scan position, extents and top label,
// and classifies each beat into a command. Depends on lbbs_pkg.
`timescale 1ns / 1ps

module lbbs_front import lbbs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [EXT_W-1:0]   i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_op,
    input  logic [LABEL_W-1:0] i_label,
    input  logic               i_q_full,
    input  logic               i_init_done,
    output logic               o_push,
    output t_cmd               o_cmd
);

    logic [EXT_W-1:0]   r_columns, r_rows, r_planes;
    logic [COORD_W-1:0] r_scan_x, r_scan_y, r_scan_z;
    logic [COORD_W-1:0] n_scan_x, n_scan_y, n_scan_z;
    logic [LABEL_W-1:0] r_top, n_top;
    logic               in_table;
    logic               wrap_x, wrap_y, wrap_z;
    t_kind              kind;

    // Zero acts as one, anything above the coordinate range as the full range
    function automatic logic [EXT_W-1:0] clamp_ext(input logic [EXT_W-1:0] v);
        if (v == '0) begin
            clamp_ext = EXT_W'(1);
        end else if (v > EXT_LIMIT) begin
            clamp_ext = EXT_LIMIT;
        end else begin
            clamp_ext = v;
        end
    endfunction

    assign o_ready  = i_init_done && !i_q_full;
    assign o_push   = i_valid && o_ready;
    assign in_table = {1'b0, i_label} < (LABEL_W + 1)'(LABEL_ENTRIES);

    assign wrap_x = ({1'b0, r_scan_x} + EXT_W'(1)) >= clamp_ext(r_columns);
    assign wrap_y = ({1'b0, r_scan_y} + EXT_W'(1)) >= clamp_ext(r_rows);
    assign wrap_z = ({1'b0, r_scan_z} + EXT_W'(1)) >= clamp_ext(r_planes);

    always_comb begin
        case (i_op)
            OP_ACC:   kind = in_table ? K_ACC : K_BAD;
            OP_READ:  kind = in_table ? K_READ : K_BAD;
            OP_CLEAR: kind = in_table ? K_CLEAR : K_BAD;
            default:  kind = K_NOP;
        endcase
    end

    always_comb begin
        n_scan_x = r_scan_x;
        n_scan_y = r_scan_y;
        n_scan_z = r_scan_z;
        n_top    = r_top;
        if (i_op == OP_ACC) begin
            // advance the raster position even when the label is out of range
            if (!wrap_x) begin
                n_scan_x = r_scan_x + COORD_W'(1);
            end else begin
                n_scan_x = '0;
                if (!wrap_y) begin
                    n_scan_y = r_scan_y + COORD_W'(1);
                end else begin
                    n_scan_y = '0;
                    n_scan_z = wrap_z ? '0 : r_scan_z + COORD_W'(1);
                end
            end
        end
        if (kind == K_ACC && i_label > r_top) begin
            n_top = i_label;
        end
        if (kind == K_CLEAR) begin
            n_scan_x = '0;
            n_scan_y = '0;
            n_scan_z = '0;
            n_top    = '0;
        end
    end

    always_comb begin
        o_cmd.kind  = kind;
        o_cmd.label = i_label;
        o_cmd.x     = r_scan_x;
        o_cmd.y     = r_scan_y;
        o_cmd.z     = r_scan_z;
        o_cmd.top   = n_top;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_columns <= EXT_LIMIT;
            r_rows    <= EXT_LIMIT;
            r_planes  <= EXT_LIMIT;
        end else if (i_cfg_we) begin
            case (i_cfg_index)
                CFG_COLUMNS: r_columns <= i_cfg_data;
                CFG_ROWS:    r_rows    <= i_cfg_data;
                CFG_PLANES:  r_planes  <= i_cfg_data;
                default:     ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_scan_x <= '0;
            r_scan_y <= '0;
            r_scan_z <= '0;
            r_top    <= '0;
        end else if (o_push) begin
            r_scan_x <= n_scan_x;
            r_scan_y <= n_scan_y;
            r_scan_z <= n_scan_z;
            r_top    <= n_top;
        end
    end

endmodule

// ===== sv/lbbs_queue.sv =====
// Short command queue between front end and table back end.
// Depends on lbbs_pkg for the command type and depth.
`timescale 1ns / 1ps

module lbbs_queue import lbbs_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_cmd i_cmd,
    input  logic i_pop,
    output t_cmd o_head,
    output logic o_full,
    output logic o_empty
);

    t_cmd              r_slot [QUEUE_DEPTH];
    logic [QPTR_W-1:0] r_wr_ptr, r_rd_ptr;
    logic [QPTR_W:0]   r_count;

    assign o_head  = r_slot[r_rd_ptr];
    assign o_full  = r_count == (QPTR_W + 1)'(QUEUE_DEPTH);
    assign o_empty = r_count == '0;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_slot[r_wr_ptr] <= i_cmd;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            if (i_push) begin
                r_wr_ptr <= r_wr_ptr + QPTR_W'(1);
            end
            if (i_pop) begin
                r_rd_ptr <= r_rd_ptr + QPTR_W'(1);
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + (QPTR_W + 1)'(1);
                2'b01:   r_count <= r_count - (QPTR_W + 1)'(1);
                default: ;
            endcase
        end
    end

    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_push && o_full))
        else $error("queue push while full");

    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(i_pop && o_empty))
        else $error("queue pop while empty");

endmodule

// ===== sv/lbbs_back.sv =====
// Back end: label table memory with clear sweep, read-modify-write per command
// and the result register. Depends on lbbs_pkg.
`timescale 1ns / 1ps

module lbbs_back import lbbs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_cmd               i_head,
    input  logic               i_empty,
    output logic               o_pop,
    output logic               o_init_done,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [LABEL_W-1:0] o_entry_label,
    output logic [COORD_W-1:0] o_min_x,
    output logic [COORD_W-1:0] o_min_y,
    output logic [COORD_W-1:0] o_min_z,
    output logic [COORD_W-1:0] o_max_x,
    output logic [COORD_W-1:0] o_max_y,
    output logic [COORD_W-1:0] o_max_z,
    output logic [TALLY_W-1:0] o_voxel_count,
    output logic [LABEL_W-1:0] o_largest_label,
    output logic               o_status
);

    typedef enum logic [2:0] {
        ST_INIT = 3'b001,
        ST_IDLE = 3'b010,
        ST_LOOK = 3'b100
    } t_bstate;

    t_bstate            r_state, n_state;
    logic [IDX_W-1:0]   r_clr_idx;
    t_entry             r_mem [LABEL_ENTRIES];
    t_entry             r_rd;
    t_entry             upd, shown;
    logic               mem_we;
    logic [IDX_W-1:0]   wr_addr, rd_addr;
    t_entry             wr_data;
    logic               out_free, load;
    logic               first;
    logic               r_out_valid;
    logic [LABEL_W-1:0] r_out_label, r_out_top;
    t_entry             r_out_entry;
    logic               r_out_status;

    assign rd_addr  = i_head.label[IDX_W-1:0];
    assign out_free = !r_out_valid || i_ready;
    assign load     = (r_state == ST_LOOK) && out_free;
    assign o_pop    = load;
    assign o_init_done = r_state != ST_INIT;

    // widen the box, or seed it on the first voxel of the label
    assign first = r_rd.tally == '0;
    always_comb begin
        upd.lo_x  = (first || i_head.x < r_rd.lo_x) ? i_head.x : r_rd.lo_x;
        upd.lo_y  = (first || i_head.y < r_rd.lo_y) ? i_head.y : r_rd.lo_y;
        upd.lo_z  = (first || i_head.z < r_rd.lo_z) ? i_head.z : r_rd.lo_z;
        upd.hi_x  = (first || i_head.x > r_rd.hi_x) ? i_head.x : r_rd.hi_x;
        upd.hi_y  = (first || i_head.y > r_rd.hi_y) ? i_head.y : r_rd.hi_y;
        upd.hi_z  = (first || i_head.z > r_rd.hi_z) ? i_head.z : r_rd.hi_z;
        upd.tally = (r_rd.tally == TALLY_MAX) ? r_rd.tally : r_rd.tally + TALLY_W'(1);
    end

    always_comb begin
        case (i_head.kind)
            K_ACC:   shown = upd;
            K_READ:  shown = r_rd;
            default: shown = '0;
        endcase
    end

    always_comb begin
        mem_we  = 1'b0;
        wr_addr = rd_addr;
        wr_data = '0;
        n_state = r_state;
        case (r_state)
            ST_INIT: begin
                mem_we  = 1'b1;
                wr_addr = r_clr_idx;
                if (r_clr_idx == IDX_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (!i_empty) begin
                    n_state = ST_LOOK;
                end
            end
            ST_LOOK: begin
                if (out_free) begin
                    mem_we  = (i_head.kind == K_ACC) || (i_head.kind == K_CLEAR);
                    wr_data = (i_head.kind == K_ACC) ? upd : '0;
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_INIT;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[wr_addr] <= wr_data;
        end
        r_rd <= r_mem[rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state   <= ST_INIT;
            r_clr_idx <= '0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_INIT) begin
                r_clr_idx <= r_clr_idx + IDX_W'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (load) begin
            r_out_valid <= 1'b1;
        end else if (i_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (load) begin
            r_out_label  <= i_head.label;
            r_out_top    <= i_head.top;
            r_out_entry  <= shown;
            r_out_status <= i_head.kind == K_BAD;
        end
    end

    assign o_valid         = r_out_valid;
    assign o_entry_label   = r_out_label;
    assign o_min_x         = r_out_entry.lo_x;
    assign o_min_y         = r_out_entry.lo_y;
    assign o_min_z         = r_out_entry.lo_z;
    assign o_max_x         = r_out_entry.hi_x;
    assign o_max_y         = r_out_entry.hi_y;
    assign o_max_z         = r_out_entry.hi_z;
    assign o_voxel_count   = r_out_entry.tally;
    assign o_largest_label = r_out_top;
    assign o_status        = r_out_status;

    a_no_result_in_sweep: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_INIT) |-> !r_out_valid)
        else $error("result present during table sweep");

    a_no_write_on_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_LOOK && !out_free) |-> !mem_we)
        else $error("table written while result stalled");

    a_load_shows_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        load |=> (r_out_valid && r_state == ST_IDLE))
        else $error("finished command did not produce a result");

endmodule

// ===== sv/label_bounding_box_stats_unit.sv =====
// Top level of the per-label bounding-box and voxel-count block.
// Instantiates lbbs_front, lbbs_queue and lbbs_back; depends on lbbs_pkg.
`timescale 1ns / 1ps

// Usage
//   Input channel (i_valid/o_ready, i_op, i_label): one beat per voxel label in
//   raster order, x fastest, or a read / clear of one table entry. Coordinates
//   come from an internal scan counter sized by the columns, rows and planes
//   registers, to be written via i_cfg_we/i_cfg_index/i_cfg_data while idle
//   (unchecked). Output channel (o_valid/i_ready): exactly one result beat per
//   input beat, in order, carrying the entry after the update, the largest
//   label so far and a status bit that flags labels beyond the table.
// Command flow
//   Each command passes through the back-end states ST_IDLE, which reads the
//   table entry into the registered read port, and ST_LOOK, which updates,
//   writes back and loads the result register once that register is free.
//   The next command is not started until the previous one is written back.
// Reset and stall
//   After reset all 4096 table entries are swept to zero, one entry per cycle;
//   o_ready stays low during the sweep. When the receiver stalls the
//   result register holds, the back end waits, and the 4-deep command queue
//   keeps taking input beats until it fills.

module label_bounding_box_stats_unit import lbbs_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic [1:0]         i_cfg_index,
    input  logic [EXT_W-1:0]   i_cfg_data,
    input  logic               i_valid,
    output logic               o_ready,
    input  logic [1:0]         i_op,
    input  logic [LABEL_W-1:0] i_label,
    output logic               o_valid,
    input  logic               i_ready,
    output logic [LABEL_W-1:0] o_entry_label,
    output logic [COORD_W-1:0] o_min_x,
    output logic [COORD_W-1:0] o_min_y,
    output logic [COORD_W-1:0] o_min_z,
    output logic [COORD_W-1:0] o_max_x,
    output logic [COORD_W-1:0] o_max_y,
    output logic [COORD_W-1:0] o_max_z,
    output logic [TALLY_W-1:0] o_voxel_count,
    output logic [LABEL_W-1:0] o_largest_label,
    output logic               o_status
);

    // front end to queue
    logic push;
    t_cmd cmd;
    // queue to back end
    t_cmd head;
    logic q_full, q_empty, pop;
    // back end sweep finished; hold off input until then
    logic init_done;

    lbbs_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .i_valid     (i_valid),
        .o_ready     (o_ready),
        .i_op        (i_op),
        .i_label     (i_label),
        .i_q_full    (q_full),
        .i_init_done (init_done),
        .o_push      (push),
        .o_cmd       (cmd)
    );

    lbbs_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (push),
        .i_cmd   (cmd),
        .i_pop   (pop),
        .o_head  (head),
        .o_full  (q_full),
        .o_empty (q_empty)
    );

    lbbs_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_head          (head),
        .i_empty         (q_empty),
        .o_pop           (pop),
        .o_init_done     (init_done),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_entry_label   (o_entry_label),
        .o_min_x         (o_min_x),
        .o_min_y         (o_min_y),
        .o_min_z         (o_min_z),
        .o_max_x         (o_max_x),
        .o_max_y         (o_max_y),
        .o_max_z         (o_max_z),
        .o_voxel_count   (o_voxel_count),
        .o_largest_label (o_largest_label),
        .o_status        (o_status)
    );

endmodule
